>>> rtl/clsup_pkg.sv
// ----------------------------------------------------------------------------
// clsup_pkg
// Shared types and codes for the clock lock supervisor.
// ----------------------------------------------------------------------------
package clsup_pkg;

    localparam int unsigned OP_W         = 3;
    localparam int unsigned CMD_W        = 2;
    localparam int unsigned NOTIFY_W     = 2;
    localparam int unsigned THRESH_W     = 8;
    localparam int unsigned CFG_IDX_W    = 1;
    localparam int unsigned CFG_DATA_W   = 8;
    localparam int unsigned S_TDATA_W    = 8;
    localparam int unsigned M_TDATA_W    = 16;

    localparam logic [THRESH_W-1:0] THRESH_RESET = 8'd8;

    localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_DETECT_EN = 1'd1;

    typedef enum logic [OP_W-1:0] {
        OP_RX_ERROR = 3'd0,
        OP_POLL     = 3'd1,
        OP_MAKE     = 3'd2,
        OP_BREAK    = 3'd3,
        OP_WAKE     = 3'd4,
        OP_RECOVER  = 3'd5
    } t_op;

    typedef enum logic [CMD_W-1:0] {
        CMD_NONE     = 2'd0,
        CMD_INTERNAL = 2'd1,
        CMD_EXTERNAL = 2'd2
    } t_cmd;

    typedef enum logic [NOTIFY_W-1:0] {
        NOTIFY_NONE     = 2'd0,
        NOTIFY_LOST     = 2'd1,
        NOTIFY_ACQUIRED = 2'd2
    } t_notify;

    typedef enum logic [2:0] {
        DET_IDLE      = 3'd0,
        DET_PREP_LOSS = 3'd1,
        DET_ARM_LOSS  = 3'd2,
        DET_TRIG_LOSS = 3'd3,
        DET_PREP_TRY  = 3'd4,
        DET_ARM_TRY   = 3'd5,
        DET_TRIG_TRY  = 3'd6
    } t_det_state;

    typedef enum logic [2:0] {
        REC_IDLE    = 3'd0,
        REC_START   = 3'd1,
        REC_DELAY   = 3'd2,
        REC_SET_INT = 3'd3,
        REC_SET_EXT = 3'd4
    } t_rec_state;

    typedef struct packed {
        logic tick;
        logic enable;
        logic aes3_seen;
    } t_det_ctl;

    typedef struct packed {
        logic tick;
        logic start;
    } t_rec_ctl;

    // Last field in the lowest bits: notify is the last member.
    typedef struct packed {
        logic    clock_source_now;
        logic    aes3_present;
        logic    unlock_flag;
        t_cmd    recovery_clock_cmd;
        t_cmd    detect_clock_cmd;
        logic    restart_transport;
        logic    disable_rx_error;
        t_notify notify;
    } t_result;

    localparam int unsigned RESULT_W = $bits(t_result);

endpackage

>>> rtl/clsup_detect.sv
// ----------------------------------------------------------------------------
// clsup_detect
// AES3 detect state machine, advanced by poll ticks.
// ----------------------------------------------------------------------------
module clsup_detect
    import clsup_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_det_ctl i_ctl,
    output t_cmd     o_cmd
);

    t_det_state r_state;
    t_det_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= DET_IDLE;
        end else if (i_ctl.tick) begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            DET_IDLE: begin
                if (i_ctl.enable) n_state = DET_PREP_TRY;
            end
            DET_PREP_LOSS: begin
                n_state = i_ctl.aes3_seen ? DET_PREP_LOSS : DET_ARM_LOSS;
            end
            DET_ARM_LOSS: begin
                n_state = i_ctl.aes3_seen ? DET_PREP_LOSS : DET_TRIG_LOSS;
            end
            DET_TRIG_LOSS: begin
                n_state = i_ctl.aes3_seen ? DET_PREP_LOSS : DET_PREP_TRY;
            end
            DET_PREP_TRY: begin
                if (i_ctl.aes3_seen) n_state = DET_ARM_TRY;
            end
            DET_ARM_TRY: begin
                if (i_ctl.aes3_seen) n_state = DET_TRIG_TRY;
            end
            DET_TRIG_TRY: begin
                if (i_ctl.aes3_seen) n_state = DET_PREP_LOSS;
            end
            default: begin
                n_state = DET_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd = CMD_NONE;
        if (i_ctl.tick) begin
            case (r_state)
                DET_TRIG_LOSS: begin
                    if (!i_ctl.aes3_seen) o_cmd = CMD_INTERNAL;
                end
                DET_TRIG_TRY: begin
                    if (i_ctl.aes3_seen) o_cmd = CMD_EXTERNAL;
                end
                default: begin
                    o_cmd = CMD_NONE;
                end
            endcase
        end
    end

endmodule

>>> rtl/clsup_recovery.sv
// ----------------------------------------------------------------------------
// clsup_recovery
// Post-switch recovery sequencer: internal then external clock command.
// ----------------------------------------------------------------------------
module clsup_recovery
    import clsup_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_rec_ctl i_ctl,
    output t_cmd     o_cmd
);

    t_rec_state r_state;
    t_rec_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= REC_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        if (i_ctl.start) begin
            n_state = REC_START;
        end else if (i_ctl.tick) begin
            case (r_state)
                REC_IDLE:    n_state = REC_IDLE;
                REC_START:   n_state = REC_DELAY;
                REC_DELAY:   n_state = REC_SET_INT;
                REC_SET_INT: n_state = REC_SET_EXT;
                REC_SET_EXT: n_state = REC_IDLE;
                default:     n_state = REC_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd = CMD_NONE;
        if (i_ctl.tick) begin
            case (r_state)
                REC_SET_INT: o_cmd = CMD_INTERNAL;
                REC_SET_EXT: o_cmd = CMD_EXTERNAL;
                default:     o_cmd = CMD_NONE;
            endcase
        end
    end

endmodule

>>> rtl/clsup_outbuf.sv
// ----------------------------------------------------------------------------
// clsup_outbuf
// Result register with a skid stage so input and output stalls stay apart.
// ----------------------------------------------------------------------------
module clsup_outbuf
    import clsup_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_ready,
    input  t_result i_item,
    output logic    o_valid,
    input  logic    i_ready,
    output t_result o_item
);

    logic    r_main_valid;
    logic    r_skid_valid;
    t_result r_main;
    t_result r_skid;
    logic    n_main_valid;
    logic    n_skid_valid;
    logic    main_free;

    assign o_ready   = !r_skid_valid;
    assign o_valid   = r_main_valid;
    assign o_item    = r_main;
    assign main_free = !r_main_valid || i_ready;

    always_comb begin
        n_main_valid = r_main_valid;
        n_skid_valid = r_skid_valid;
        if (main_free) begin
            n_main_valid = r_skid_valid || i_valid;
            n_skid_valid = 1'b0;
        end else if (i_valid && !r_skid_valid) begin
            n_skid_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_main_valid <= n_main_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (main_free) begin
            r_main <= r_skid_valid ? r_skid : i_item;
        end else if (i_valid && !r_skid_valid) begin
            r_skid <= i_item;
        end
    end

endmodule

>>> rtl/digital_audio_clock_lock_supervisor.sv
// ----------------------------------------------------------------------------
// digital_audio_clock_lock_supervisor
// Clock lock supervision for an S/PDIF receiver.
// ----------------------------------------------------------------------------
// Each control event (receiver error, poll tick, clock-select make or break,
// wake, recovery request) is taken on the slave stream and yields exactly one
// result item on the master stream. An event is processed in the cycle it is
// accepted and its result is registered, so one event per clock is sustained
// unless the skid stage is full and tready drops. A two-entry output buffer
// (result register plus skid stage) keeps tready high while one result waits.
// Configuration writes are accepted at any time (o_cfg_ready is always high)
// and should be issued only while no event is in flight.
module digital_audio_clock_lock_supervisor
    import clsup_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // [2:0] op, [3] phase_locked, [4] confidence_error, [5] biphase_error,
    // [6] clock_select, [7] digital_input
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // [1:0] notify, [2] disable_rx_error, [3] restart_transport,
    // [5:4] detect_clock_cmd, [7:6] recovery_clock_cmd, [8] unlock_flag,
    // [9] aes3_present, [10] clock_source_now, [15:11] zero
    output logic [M_TDATA_W-1:0]  o_m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    logic [THRESH_W-1:0] r_unlock_threshold;
    logic                r_detect_enable;
    logic [THRESH_W-1:0] r_unlock_count;
    logic                r_unlock_sticky;
    logic                r_attempting_lock;
    logic                r_aes3_seen;
    logic                r_current_source;

    logic [THRESH_W-1:0] n_unlock_count;
    logic                n_unlock_sticky;
    logic                n_attempting_lock;
    logic                n_aes3_seen;
    logic                n_current_source;

    logic                in_accept;
    t_op                 op;
    logic                phase_locked;
    logic                confidence_error;
    logic                biphase_error;
    logic                clock_select;
    logic                digital_input;
    logic [THRESH_W-1:0] count_bumped;

    t_det_ctl            det_ctl;
    t_rec_ctl            rec_ctl;
    t_cmd                det_cmd;
    t_cmd                rec_cmd;
    t_result             result;
    t_result             out_item;
    logic                buf_ready;

    assign in_accept        = i_s_axis_tvalid && buf_ready;
    assign o_s_axis_tready  = buf_ready;
    assign o_cfg_ready      = 1'b1;

    assign op               = t_op'(i_s_axis_tdata[2:0]);
    assign phase_locked     = i_s_axis_tdata[3];
    assign confidence_error = i_s_axis_tdata[4];
    assign biphase_error    = i_s_axis_tdata[5];
    assign clock_select     = i_s_axis_tdata[6];
    assign digital_input    = i_s_axis_tdata[7];

    // Count saturates at the threshold.
    assign count_bumped = (r_unlock_count < r_unlock_threshold) ?
                          r_unlock_count + 1'b1 : r_unlock_count;

    always_comb begin
        n_unlock_count    = r_unlock_count;
        n_unlock_sticky   = r_unlock_sticky;
        n_attempting_lock = r_attempting_lock;
        n_aes3_seen       = r_aes3_seen;
        n_current_source  = r_current_source;
        det_ctl           = '{tick: 1'b0, enable: r_detect_enable,
                              aes3_seen: r_aes3_seen};
        rec_ctl           = '{tick: 1'b0, start: 1'b0};
        result            = '0;
        case (op)
            OP_RX_ERROR: begin
                if (!phase_locked) begin
                    n_unlock_count = count_bumped;
                    if (count_bumped >= r_unlock_threshold) begin
                        n_unlock_sticky         = 1'b1;
                        result.disable_rx_error = 1'b1;
                        result.notify           = NOTIFY_LOST;
                        n_unlock_count          = '0;
                        n_attempting_lock       = 1'b0;
                    end
                end else begin
                    n_unlock_count = '0;
                    if (r_attempting_lock) begin
                        result.notify     = NOTIFY_ACQUIRED;
                        n_attempting_lock = 1'b0;
                    end
                end
                n_aes3_seen = !confidence_error && !biphase_error;
            end
            OP_POLL: begin
                det_ctl.tick = 1'b1;
                rec_ctl.tick = 1'b1;
            end
            OP_MAKE: begin
                if (clock_select && digital_input) begin
                    result.restart_transport = 1'b1;
                    n_attempting_lock        = 1'b1;
                end
                if (!clock_select && digital_input) begin
                    n_unlock_sticky = 1'b0;
                    rec_ctl.start   = 1'b1;
                end
                n_current_source = clock_select;
                n_unlock_count   = '0;
            end
            OP_BREAK: begin
                n_attempting_lock = 1'b0;
                n_unlock_count    = '0;
            end
            OP_WAKE: begin
                rec_ctl.start = !r_current_source;
            end
            OP_RECOVER: begin
                rec_ctl.start = 1'b1;
            end
            default: begin
                n_unlock_count = r_unlock_count;
            end
        endcase
        det_ctl.tick  = det_ctl.tick && in_accept;
        rec_ctl.tick  = rec_ctl.tick && in_accept;
        rec_ctl.start = rec_ctl.start && in_accept;
        result.detect_clock_cmd   = det_cmd;
        result.recovery_clock_cmd = rec_cmd;
        result.unlock_flag        = n_unlock_sticky;
        result.aes3_present       = n_aes3_seen;
        result.clock_source_now   = n_current_source;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_unlock_threshold <= THRESH_RESET;
            r_detect_enable    <= 1'b0;
            r_unlock_count     <= '0;
            r_unlock_sticky    <= 1'b0;
            r_attempting_lock  <= 1'b0;
            r_aes3_seen        <= 1'b0;
            r_current_source   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: r_unlock_threshold <= i_cfg_data;
                    CFG_DETECT_EN: r_detect_enable    <= i_cfg_data[0];
                    default:       r_detect_enable    <= r_detect_enable;
                endcase
            end
            if (in_accept) begin
                r_unlock_count    <= n_unlock_count;
                r_unlock_sticky   <= n_unlock_sticky;
                r_attempting_lock <= n_attempting_lock;
                r_aes3_seen       <= n_aes3_seen;
                r_current_source  <= n_current_source;
            end
        end
    end

    clsup_detect u_detect (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (det_ctl),
        .o_cmd   (det_cmd)
    );

    clsup_recovery u_recovery (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (rec_ctl),
        .o_cmd   (rec_cmd)
    );

    clsup_outbuf u_outbuf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_s_axis_tvalid),
        .o_ready (buf_ready),
        .i_item  (result),
        .o_valid (o_m_axis_tvalid),
        .i_ready (i_m_axis_tready),
        .o_item  (out_item)
    );

    assign o_m_axis_tdata = {{(M_TDATA_W - RESULT_W){1'b0}}, out_item};

endmodule

>>> rtl/clsup_checker.sv
// ----------------------------------------------------------------------------
// clsup_checker
// Port-level checks for the clock lock supervisor, bound to the top level.
// ----------------------------------------------------------------------------
module clsup_checker
    import clsup_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    input  logic                  o_s_axis_tready,
    input  logic [S_TDATA_W-1:0]  i_s_axis_tdata,
    input  logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    input  logic [M_TDATA_W-1:0]  o_m_axis_tdata
);

    // Input side stalls only while a result is held on the output.
    a_stall_needs_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_s_axis_tready |-> o_m_axis_tvalid)
        else $error("input stalled with no pending result");

    // An accepted event with an empty output shows up on the output in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready && !o_m_axis_tvalid) |=> o_m_axis_tvalid)
        else $error("accepted event produced no result");

    // Lock-loss report carries the interrupt disable and the sticky flag.
    a_loss_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && o_m_axis_tdata[2]) |->
            (o_m_axis_tdata[1:0] == NOTIFY_LOST && o_m_axis_tdata[8]))
        else $error("lock loss fields disagree");

    // Clock commands and notify never carry the unused code.
    a_codes_legal: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |->
            (o_m_axis_tdata[1:0] != 2'd3 && o_m_axis_tdata[5:4] != 2'd3 &&
             o_m_axis_tdata[7:6] != 2'd3))
        else $error("illegal code in result");

endmodule

bind digital_audio_clock_lock_supervisor clsup_checker u_clsup_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .i_s_axis_tdata  (i_s_axis_tdata),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata)
);
